FILE: sv/psrs_pkg.sv
// ----------------------------------------------------------------------------
// Photo switch rotation sequencer package
// Shared codes, constants and interface types for the sequencer and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package psrs_pkg;

    // Switch history depth and saturating history count
    localparam int HIST_DEPTH = 10;
    localparam logic [3:0] HIST_LEN_MAX = 4'd15;

    // Brake pulse
    localparam logic [7:0] BRAKE_TICKS = 8'd20;
    localparam logic [7:0] BRAKE_LEVEL = 8'd55;

    localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;
    localparam logic [23:0] HOLD_INIT_TICKS = 24'd1000;
    localparam logic [6:0] SPEED_MAX = 7'd100;

    // Opcodes carried in s_tuser; the spare code is ignored by the block.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAIN_SPEED = 3'd0;
    localparam logic [2:0] CFG_PUMP_SPEED = 3'd1;
    localparam logic [2:0] CFG_HOLD_PUMP_PREP = 3'd2;
    localparam logic [2:0] CFG_HOLD_PUMP_FINAL = 3'd3;
    localparam logic [2:0] CFG_HOLD_RETURN_FIRST = 3'd4;
    localparam logic [2:0] CFG_HOLD_DRAIN_PREP = 3'd5;
    localparam logic [2:0] CFG_HOLD_DRAIN_FINAL = 3'd6;
    localparam logic [2:0] CFG_HOLD_RETURN_SECOND = 3'd7;

    // Station codes
    localparam logic [2:0] STATION_ZERO = 3'd0;
    localparam logic [2:0] STATION_PUMP_PREP = 3'd1;
    localparam logic [2:0] STATION_PUMP_FINAL = 3'd2;
    localparam logic [2:0] STATION_DRAIN_PREP = 3'd3;
    localparam logic [2:0] STATION_DRAIN_FINAL = 3'd4;
    localparam logic [2:0] STATION_UNKNOWN = 3'd5;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ROTATE = 2'd1,
        MODE_HOLD = 2'd2
    } psrs_mode_t;

    typedef enum logic [2:0] {
        STEP_FIND_ZERO = 3'd0,
        STEP_PUMP_SETUP = 3'd1,
        STEP_PUMP_FINAL = 3'd2,
        STEP_RETURN_FIRST = 3'd3,
        STEP_DRAIN_SETUP = 3'd4,
        STEP_DRAIN_FINAL = 3'd5,
        STEP_RETURN_SECOND = 3'd6,
        STEP_DONE = 3'd7
    } psrs_step_t;

    typedef struct packed {
        logic sample_en;
        logic clear;
    } psrs_sw_ctrl_t;

    typedef struct packed {
        logic stable;
        logic [HIST_DEPTH-1:0] history;
        logic [3:0] history_len;
    } psrs_sw_view_t;

endpackage

`default_nettype wire

FILE: sv/psrs_debounce.sv
// ----------------------------------------------------------------------------
// Photo switch debouncer
// Two-sample debounce of one switch with a shift history of stable changes.
// ----------------------------------------------------------------------------
`default_nettype none

module psrs_debounce import psrs_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          raw,
    input  wire psrs_sw_ctrl_t ctrl,
    output psrs_sw_view_t      view
);

    logic                  prev_sample_reg;
    logic                  stable_reg;
    logic [HIST_DEPTH-1:0] history_reg;
    logic [3:0]            history_len_reg;
    logic                  change;

    // The view is what the switch looks like once this tick's sample is taken.
    always_comb begin
        change = (raw == prev_sample_reg) && (stable_reg != raw);
        view.stable = stable_reg;
        view.history = history_reg;
        view.history_len = history_len_reg;
        if (change) begin
            view.stable = raw;
            view.history = {history_reg[HIST_DEPTH-2:0], raw};
            view.history_len = (history_len_reg == HIST_LEN_MAX) ?
                               HIST_LEN_MAX : history_len_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= 1'b0;
            stable_reg <= 1'b0;
            history_reg <= '0;
            history_len_reg <= '0;
        end else begin
            if (ctrl.sample_en) begin
                prev_sample_reg <= raw;
                stable_reg <= view.stable;
            end
            if (ctrl.clear) begin
                history_reg <= '0;
                history_len_reg <= '0;
            end else if (ctrl.sample_en) begin
                history_reg <= view.history;
                history_len_reg <= view.history_len;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/photo_switch_rotation_sequencer.sv
// ----------------------------------------------------------------------------
// Photo switch rotation sequencer
// Output: one result beat per input beat, registered and valid in the cycle after acceptance.
// Throughput: one beat per clock; the flow update is one pass of logic between
// the state registers and the output register, which stalls only on m_tready.
// Reset: synchronous, active low; flow idle, station unknown, registers at
// their defaults, histories cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module photo_switch_rotation_sequencer import psrs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    input  wire logic [23:0] s_tdata,   // [15:0] cycle_request, [16] switch_a_level,
                                        // [17] switch_b_level, [23:18] zero
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] main_drive, [14:8] pump_drive,
                                        // [15] arrived, [18:16] station,
                                        // [19] finished, [23:20] zero
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);

    logic        s_accept;
    logic [1:0]  op;
    logic [15:0] cycle_request;

    logic [6:0]  main_speed_reg, pump_speed_reg;
    logic [23:0] hold_pump_prep_reg, hold_pump_final_reg, hold_return_first_reg;
    logic [23:0] hold_drain_prep_reg, hold_drain_final_reg, hold_return_second_reg;
    logic [6:0]  speed_wr;

    psrs_mode_t  flow_mode_reg, flow_mode_next;
    psrs_step_t  flow_step_reg, flow_step_next;
    logic [2:0]  station_reg, station_next;
    logic        motor_on_reg, motor_on_next;
    logic        turning_cw_reg, turning_cw_next;
    logic [23:0] hold_timer_reg, hold_timer_next;
    logic [15:0] cycles_left_reg, cycles_left_next;
    logic        reported_reg, reported_next;
    logic        brake_on_reg, brake_on_next;
    logic [7:0]  brake_timer_reg, brake_timer_next;
    logic [7:0]  main_drive_reg, main_drive_next;
    logic [6:0]  pump_drive_reg, pump_drive_next;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    psrs_sw_ctrl_t ctrl_a, ctrl_b;
    psrs_sw_view_t view_a, view_b;
    logic          sample_req, clear_req;
    logic          arrived;
    logic          at_zero;
    logic [23:0]   hold_limit;
    logic [7:0]    brake_count;
    logic [2:0]    station_out;
    logic          finished;

    function automatic logic [7:0] speed_cmd(input logic cw, input logic [6:0] sp);
        return cw ? {1'b0, sp} : 8'(8'd0 - {1'b0, sp});
    endfunction

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign op = s_tuser;
    assign cycle_request = s_tdata[15:0];

    assign ctrl_a = '{sample_en: s_accept && sample_req, clear: s_accept && clear_req};
    assign ctrl_b = ctrl_a;

    psrs_debounce u_debounce_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .raw     (s_tdata[16]),
        .ctrl    (ctrl_a),
        .view    (view_a)
    );

    psrs_debounce u_debounce_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .raw     (s_tdata[17]),
        .ctrl    (ctrl_b),
        .view    (view_b)
    );

    assign at_zero = view_a.stable && view_b.stable;
    assign brake_count = (brake_timer_reg == 8'hFF) ? 8'hFF : brake_timer_reg + 8'd1;

    always_comb begin
        case (flow_step_reg)
            STEP_FIND_ZERO:     hold_limit = HOLD_INIT_TICKS;
            STEP_PUMP_SETUP:    hold_limit = hold_pump_prep_reg;
            STEP_PUMP_FINAL:    hold_limit = hold_pump_final_reg;
            STEP_RETURN_FIRST:  hold_limit = hold_return_first_reg;
            STEP_DRAIN_SETUP:   hold_limit = hold_drain_prep_reg;
            STEP_DRAIN_FINAL:   hold_limit = hold_drain_final_reg;
            STEP_RETURN_SECOND: hold_limit = hold_return_second_reg;
            default:            hold_limit = '0;
        endcase
    end

    // One item: the flow update is written in the order the actions take effect,
    // so later assignments see the motor state left by earlier ones.
    always_comb begin
        flow_mode_next = flow_mode_reg;
        flow_step_next = flow_step_reg;
        station_next = station_reg;
        motor_on_next = motor_on_reg;
        turning_cw_next = turning_cw_reg;
        hold_timer_next = hold_timer_reg;
        cycles_left_next = cycles_left_reg;
        reported_next = reported_reg;
        brake_on_next = brake_on_reg;
        brake_timer_next = brake_timer_reg;
        main_drive_next = main_drive_reg;
        pump_drive_next = pump_drive_reg;
        sample_req = 1'b0;
        clear_req = 1'b0;
        arrived = 1'b0;

        case (op)
            OP_TICK: begin
                sample_req = 1'b1;
                if (hold_timer_reg != TIMER_MAX) begin
                    hold_timer_next = hold_timer_reg + 24'd1;
                end
                if (brake_on_reg) begin
                    brake_timer_next = brake_count;
                    if (brake_count >= BRAKE_TICKS) begin
                        main_drive_next = '0;
                        brake_on_next = 1'b0;
                        motor_on_next = 1'b0;
                    end else begin
                        // The pulse is still running: the tick only counts.
                        sample_req = 1'b0;
                    end
                end
                if (sample_req && !(flow_mode_reg == MODE_IDLE && cycles_left_reg == '0)) begin
                    case (flow_mode_reg)
                        MODE_ROTATE: begin
                            pump_drive_next = '0;
                            if (flow_step_reg == STEP_FIND_ZERO) begin
                                if (at_zero) begin
                                    station_next = STATION_ZERO;
                                    flow_step_next = STEP_PUMP_SETUP;
                                    clear_req = 1'b1;
                                    turning_cw_next = 1'b0;
                                    main_drive_next = speed_cmd(1'b0, main_speed_reg);
                                    motor_on_next = 1'b1;
                                end else if (!motor_on_next) begin
                                    turning_cw_next = 1'b1;
                                    main_drive_next = speed_cmd(1'b1, main_speed_reg);
                                    motor_on_next = 1'b1;
                                end
                            end else if (flow_step_reg == STEP_DONE) begin
                                if (motor_on_next) begin
                                    main_drive_next = '0;
                                    motor_on_next = 1'b0;
                                end
                                flow_mode_next = MODE_IDLE;
                                if (cycles_left_reg != '0) begin
                                    cycles_left_next = cycles_left_reg - 16'd1;
                                    if (cycles_left_next != '0) begin
                                        flow_step_next = STEP_FIND_ZERO;
                                        flow_mode_next = MODE_ROTATE;
                                    end
                                end
                            end else begin
                                case (flow_step_reg)
                                    STEP_PUMP_SETUP: begin
                                        arrived = view_a.history_len >= 4'd2 &&
                                                  view_a.history[1:0] == 2'b01;
                                        station_next = STATION_PUMP_PREP;
                                    end
                                    STEP_PUMP_FINAL: begin
                                        arrived = view_a.history_len >= 4'd2 &&
                                                  view_a.history[1:0] == 2'b01;
                                        station_next = STATION_PUMP_FINAL;
                                    end
                                    STEP_DRAIN_SETUP: begin
                                        arrived = view_b.history_len >= 4'd4 &&
                                                  view_b.history[3:0] == 4'b0101;
                                        station_next = STATION_DRAIN_PREP;
                                    end
                                    STEP_DRAIN_FINAL: begin
                                        arrived = view_b.history_len >= 4'd3 &&
                                                  view_b.history[2:0] == 3'b010;
                                        station_next = STATION_DRAIN_FINAL;
                                    end
                                    default: begin
                                        arrived = at_zero;
                                        station_next = STATION_ZERO;
                                    end
                                endcase
                                // arrived here is only the detection; the event goes out
                                // on the first sampled tick in hold.
                                if (arrived) begin
                                    if (motor_on_next) begin
                                        brake_on_next = 1'b1;
                                        brake_timer_next = '0;
                                        main_drive_next = turning_cw_next ?
                                                          8'(8'd0 - BRAKE_LEVEL) : BRAKE_LEVEL;
                                    end
                                    flow_mode_next = MODE_HOLD;
                                    hold_timer_next = '0;
                                    reported_next = 1'b0;
                                    pump_drive_next = (flow_step_reg == STEP_RETURN_FIRST ||
                                                       flow_step_reg == STEP_RETURN_SECOND) ?
                                                      7'd0 : pump_speed_reg;
                                end else begin
                                    station_next = station_reg;
                                end
                                arrived = 1'b0;
                            end
                        end
                        MODE_HOLD: begin
                            if (!reported_reg) begin
                                arrived = 1'b1;
                                reported_next = 1'b1;
                            end
                            if (hold_timer_next >= hold_limit) begin
                                pump_drive_next = '0;
                                flow_mode_next = MODE_ROTATE;
                                case (flow_step_reg)
                                    STEP_FIND_ZERO: begin
                                        flow_step_next = STEP_PUMP_SETUP;
                                        clear_req = 1'b1;
                                        turning_cw_next = 1'b0;
                                    end
                                    STEP_PUMP_SETUP: begin
                                        flow_step_next = STEP_PUMP_FINAL;
                                        clear_req = 1'b1;
                                        turning_cw_next = 1'b0;
                                    end
                                    STEP_PUMP_FINAL: begin
                                        flow_step_next = STEP_RETURN_FIRST;
                                        turning_cw_next = 1'b1;
                                    end
                                    STEP_RETURN_FIRST: begin
                                        flow_step_next = STEP_DRAIN_SETUP;
                                        clear_req = 1'b1;
                                        turning_cw_next = 1'b1;
                                    end
                                    STEP_DRAIN_SETUP: begin
                                        flow_step_next = STEP_DRAIN_FINAL;
                                        clear_req = 1'b1;
                                        turning_cw_next = 1'b0;
                                    end
                                    STEP_DRAIN_FINAL: begin
                                        flow_step_next = STEP_RETURN_SECOND;
                                        turning_cw_next = 1'b0;
                                    end
                                    STEP_RETURN_SECOND: begin
                                        flow_step_next = STEP_DONE;
                                    end
                                    default: begin
                                        flow_mode_next = MODE_IDLE;
                                    end
                                endcase
                                // Every move out of a station restarts the motor except
                                // the last return and the complete step.
                                if (flow_step_reg != STEP_RETURN_SECOND &&
                                    flow_step_reg != STEP_DONE) begin
                                    main_drive_next = speed_cmd(turning_cw_next, main_speed_reg);
                                    motor_on_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (motor_on_next) begin
                                main_drive_next = '0;
                                motor_on_next = 1'b0;
                            end
                            pump_drive_next = '0;
                            flow_mode_next = MODE_IDLE;
                        end
                    endcase
                end
            end
            OP_START: begin
                if (motor_on_reg) begin
                    main_drive_next = '0;
                    motor_on_next = 1'b0;
                end
                pump_drive_next = '0;
                cycles_left_next = (cycle_request == '0) ? 16'd1 : cycle_request;
                flow_step_next = STEP_FIND_ZERO;
                flow_mode_next = MODE_ROTATE;
                clear_req = 1'b1;
            end
            OP_STOP: begin
                if (motor_on_reg) begin
                    main_drive_next = '0;
                    motor_on_next = 1'b0;
                end
                pump_drive_next = '0;
                flow_mode_next = MODE_IDLE;
                cycles_left_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign station_out = (station_next > STATION_UNKNOWN) ? STATION_UNKNOWN : station_next;
    assign finished = (flow_mode_next == MODE_IDLE) && (cycles_left_next == '0);
    assign speed_wr = (cfg_wdata[6:0] > SPEED_MAX) ? SPEED_MAX : cfg_wdata[6:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_speed_reg <= SPEED_MAX;
            pump_speed_reg <= SPEED_MAX;
            hold_pump_prep_reg <= 24'd2000;
            hold_pump_final_reg <= 24'd6000;
            hold_return_first_reg <= 24'd5000;
            hold_drain_prep_reg <= 24'd2000;
            hold_drain_final_reg <= 24'd10000;
            hold_return_second_reg <= 24'd1000;
            flow_mode_reg <= MODE_IDLE;
            flow_step_reg <= STEP_FIND_ZERO;
            station_reg <= STATION_UNKNOWN;
            motor_on_reg <= 1'b0;
            turning_cw_reg <= 1'b0;
            hold_timer_reg <= '0;
            cycles_left_reg <= '0;
            reported_reg <= 1'b0;
            brake_on_reg <= 1'b0;
            brake_timer_reg <= '0;
            main_drive_reg <= '0;
            pump_drive_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                flow_mode_reg <= flow_mode_next;
                flow_step_reg <= flow_step_next;
                station_reg <= station_next;
                motor_on_reg <= motor_on_next;
                turning_cw_reg <= turning_cw_next;
                hold_timer_reg <= hold_timer_next;
                cycles_left_reg <= cycles_left_next;
                reported_reg <= reported_next;
                brake_on_reg <= brake_on_next;
                brake_timer_reg <= brake_timer_next;
                main_drive_reg <= main_drive_next;
                pump_drive_reg <= pump_drive_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAIN_SPEED: begin
                        main_speed_reg <= speed_wr;
                        // A running motor, braking included, follows the new speed.
                        if (motor_on_reg) begin
                            main_drive_reg <= speed_cmd(turning_cw_reg, speed_wr);
                        end
                    end
                    CFG_PUMP_SPEED:         pump_speed_reg <= speed_wr;
                    CFG_HOLD_PUMP_PREP:     hold_pump_prep_reg <= cfg_wdata;
                    CFG_HOLD_PUMP_FINAL:    hold_pump_final_reg <= cfg_wdata;
                    CFG_HOLD_RETURN_FIRST:  hold_return_first_reg <= cfg_wdata;
                    CFG_HOLD_DRAIN_PREP:    hold_drain_prep_reg <= cfg_wdata;
                    CFG_HOLD_DRAIN_FINAL:   hold_drain_final_reg <= cfg_wdata;
                    CFG_HOLD_RETURN_SECOND: hold_return_second_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {4'd0, finished, station_out, arrived, pump_drive_next,
                            main_drive_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire

FILE: sv/psrs_checker.sv
// ----------------------------------------------------------------------------
// Photo switch rotation sequencer port checker
// Concurrent checks on the stream ports of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psrs_checker import psrs_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Every accepted input beat yields a result beat in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    // Only a tick can report an arrival.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != OP_TICK |=> !m_tdata[15])
        else $error("arrival reported on a command beat");

    // A stop leaves the flow finished with the pump off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_STOP |=> m_tdata[19] && m_tdata[14:8] == 7'd0)
        else $error("stop did not finish the flow");

endmodule

bind photo_switch_rotation_sequencer psrs_checker u_psrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
